// ===== rtl/core/dhkt_pkg.sv =====
// shared types, constants and state codes for the double hash key table
// no dependencies

package dhkt_pkg;

   localparam int TABLE_DEPTH_DEF   = 1024;
   localparam int MAX_KEY_CHARS_DEF = 8;
   localparam int SIZE_W            = 11;
   localparam int DIVIDEND_W        = 32;

   localparam logic [31:0] DJB2_SEED = 32'd5381;

   localparam logic       OP_INSERT = 1'b0;
   localparam logic       OP_LOOKUP = 1'b1;

   localparam logic [2:0] STATUS_INSERTED  = 3'd0;
   localparam logic [2:0] STATUS_UPDATED   = 3'd1;
   localparam logic [2:0] STATUS_FULL      = 3'd2;
   localparam logic [2:0] STATUS_FOUND     = 3'd3;
   localparam logic [2:0] STATUS_NOT_FOUND = 3'd4;

   typedef struct packed {
      logic        operation;
      logic [63:0] key_word;
      logic [3:0]  key_length;
      logic [63:0] payload;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [63:0] record;
      logic [9:0]  slot;
      logic [10:0] entry_count;
   } rsp_type;

   typedef struct packed {
      logic        valid;
      logic [3:0]  key_length;
      logic [63:0] key_word;
      logic [63:0] record;
   } entry_type;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_HASH,
      S_HOME,
      S_STEP,
      S_READ,
      S_CHECK,
      S_EMIT
   } state_type;

   function automatic logic [31:0] magnitude32(input logic [31:0] h);
      return h[31] ? (32'd0 - h) : h;
   endfunction

endpackage

// ===== rtl/core/dhkt_rem.sv =====
// bit-serial remainder unit, one dividend bit per cycle
// depends on dhkt_pkg

module dhkt_rem import dhkt_pkg::*; #(
   parameter int DW = 11
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DIVIDEND_W-1:0] dividend,
   input  logic [DW-1:0]         divisor,
   output logic                  done,
   output logic [DW-1:0]         remainder
);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [4:0]            cnt_ff, cnt_in;
   logic [DIVIDEND_W-1:0] q_ff, q_in;
   logic [DW-1:0]         r_ff, r_in;
   logic [DW-1:0]         d_ff, d_in;
   logic [DW:0]           trial;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      q_in    = q_ff;
      r_in    = r_ff;
      d_in    = d_ff;
      trial   = {r_ff, q_ff[DIVIDEND_W-1]};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         q_in    = dividend;
         r_in    = '0;
         d_in    = divisor;
      end else if (busy_ff) begin
         if (trial >= {1'b0, d_ff}) begin
            r_in = DW'(trial - {1'b0, d_ff});
         end else begin
            r_in = DW'(trial);
         end
         q_in   = {q_ff[DIVIDEND_W-2:0], 1'b0};
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'd31) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      q_ff   <= q_in;
      r_ff   <= r_in;
      d_ff   <= d_in;
   end

   assign done      = done_ff;
   assign remainder = r_ff;

endmodule

// ===== rtl/core/double_hash_key_table.sv =====
// order: key hashing, then home index and step in turn in the shared remainder unit,
// then a read and a check state per probed slot (registered table read), then the emit
// state to the output register, longer while an earlier result is stalled
// throughput: one request at a time; the next is taken only after the result is emitted
// reset: synchronous; clears control state, then a clearing pass writes every slot
// invalid, one slot per cycle, before the first request is taken
// depends on dhkt_pkg and dhkt_rem

module double_hash_key_table import dhkt_pkg::*; #(
   parameter int TABLE_DEPTH   = TABLE_DEPTH_DEF,
   parameter int MAX_KEY_CHARS = MAX_KEY_CHARS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  req_type           req_payload,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output rsp_type           rsp_payload,
   input  logic              csr_write_enable,
   input  logic [SIZE_W-1:0] csr_write_data
);

   localparam int AW  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int TSW = $clog2(TABLE_DEPTH + 1);

   state_type state_ff, state_in;

   logic [TSW-1:0] ts_ff, ts_in;
   logic [TSW-1:0] cnt_ff, cnt_in;
   logic [AW-1:0]  clr_ff, clr_in;
   logic           op_ff, op_in;
   logic [63:0]    key_ff, key_in;
   logic [63:0]    sh_ff, sh_in;
   logic [3:0]     len_ff, len_in;
   logic [63:0]    pay_ff, pay_in;
   logic [3:0]     ci_ff, ci_in;
   logic [31:0]    h1_ff, h1_in;
   logic [31:0]    h2_ff, h2_in;
   logic [AW-1:0]  idx_ff, idx_in;
   logic [AW-1:0]  home_ff, home_in;
   logic [AW-1:0]  step_ff, step_in;
   rsp_type        res_ff, res_in;
   logic           rsp_valid_ff, rsp_valid_in;
   rsp_type        rsp_ff, rsp_in;

   entry_type      mem [TABLE_DEPTH];
   entry_type      rd_ff;
   logic           mem_we;
   logic [AW-1:0]  mem_wa;
   entry_type      mem_wd;

   logic                  div_start;
   logic [DIVIDEND_W-1:0] div_dividend;
   logic [TSW-1:0]        div_divisor;
   logic                  div_done;
   logic [TSW-1:0]        div_rem;

   logic           accept;
   logic           emit;
   logic [3:0]     len_clamp;
   logic [63:0]    key_mask;
   logic [31:0]    c;
   logic [AW:0]    nidx_sum;
   logic [AW-1:0]  nidx;
   logic           match;
   logic [31:0]    idx_ext;
   logic [31:0]    cnt_ext;
   logic [31:0]    csr_ext;

   assign accept = req_valid && !req_stall;
   assign emit   = !rsp_valid_ff || !rsp_stall;
   assign c      = {24'd0, sh_ff[7:0]};
   assign match  = (rd_ff.key_length == len_ff) && (rd_ff.key_word == key_ff);
   assign nidx_sum = {1'b0, idx_ff} + {1'b0, step_ff};
   assign nidx   = (nidx_sum >= (AW+1)'(ts_ff)) ? AW'(nidx_sum - (AW+1)'(ts_ff))
                                                : AW'(nidx_sum);
   assign idx_ext = 32'(idx_ff);
   assign cnt_ext = 32'(cnt_in);
   assign csr_ext = 32'(csr_write_data);

   always_comb begin
      len_clamp = (32'(req_payload.key_length) > MAX_KEY_CHARS) ? 4'(MAX_KEY_CHARS)
                                                                : req_payload.key_length;
      for (int b = 0; b < 8; b++) begin
         key_mask[8*b +: 8] = (b < 32'(len_clamp)) ? 8'hFF : 8'h00;
      end
   end

   dhkt_rem #(.DW(TSW)) u_rem (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .done      (div_done),
      .remainder (div_rem)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_CLEAR: if (clr_ff == AW'(TABLE_DEPTH - 1)) state_in = S_IDLE;
         S_IDLE:  if (accept) state_in = S_HASH;
         S_HASH:  if (ci_ff == len_ff) state_in = S_HOME;
         S_HOME:  if (div_done) state_in = S_STEP;
         S_STEP:  if (div_done) state_in = S_READ;
         S_READ:  state_in = S_CHECK;
         S_CHECK: begin
            if (!rd_ff.valid || match || nidx == home_ff) state_in = S_EMIT;
            else state_in = S_READ;
         end
         S_EMIT:  if (emit) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      ts_in   = ts_ff;
      cnt_in  = cnt_ff;
      clr_in  = clr_ff;
      op_in   = op_ff;
      key_in  = key_ff;
      sh_in   = sh_ff;
      len_in  = len_ff;
      pay_in  = pay_ff;
      ci_in   = ci_ff;
      h1_in   = h1_ff;
      h2_in   = h2_ff;
      idx_in  = idx_ff;
      home_in = home_ff;
      step_in = step_ff;
      res_in  = res_ff;
      rsp_in  = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      mem_we  = 1'b0;
      mem_wa  = idx_ff;
      mem_wd  = '{valid: 1'b1, key_length: len_ff, key_word: key_ff, record: pay_ff};
      div_start    = 1'b0;
      div_dividend = magnitude32(h1_ff);
      div_divisor  = ts_ff;

      if (rsp_valid_ff && !rsp_stall) rsp_valid_in = 1'b0;

      if (csr_write_enable) begin
         if (csr_ext < 32'd2) ts_in = TSW'(2);
         else if (csr_ext > TABLE_DEPTH) ts_in = TSW'(TABLE_DEPTH);
         else ts_in = TSW'(csr_ext);
      end

      unique case (state_ff)
         S_CLEAR: begin
            mem_we = 1'b1;
            mem_wa = clr_ff;
            mem_wd = '0;
            clr_in = clr_ff + AW'(1);
         end
         S_IDLE: begin
            if (accept) begin
               op_in  = req_payload.operation;
               key_in = req_payload.key_word & key_mask;
               sh_in  = req_payload.key_word & key_mask;
               len_in = len_clamp;
               pay_in = req_payload.payload;
               ci_in  = '0;
               h1_in  = DJB2_SEED;
               h2_in  = '0;
            end
         end
         S_HASH: begin
            if (ci_ff == len_ff) begin
               div_start    = 1'b1;
               div_dividend = magnitude32(h1_ff);
               div_divisor  = ts_ff;
            end else begin
               h1_in = (h1_ff << 5) + h1_ff + c;
               h2_in = c + (h2_ff << 6) + (h2_ff << 16) - h2_ff;
               sh_in = {8'd0, sh_ff[63:8]};
               ci_in = ci_ff + 4'd1;
            end
         end
         S_HOME: begin
            if (div_done) begin
               idx_in       = AW'(div_rem);
               home_in      = AW'(div_rem);
               div_start    = 1'b1;
               div_dividend = magnitude32(h2_ff);
               div_divisor  = ts_ff - TSW'(1);
            end
         end
         S_STEP: begin
            if (div_done) step_in = AW'(div_rem) + AW'(1);
         end
         S_READ: begin
         end
         S_CHECK: begin
            res_in.record      = '0;
            res_in.slot        = '0;
            res_in.status      = (op_ff == OP_INSERT) ? STATUS_FULL : STATUS_NOT_FOUND;
            if (!rd_ff.valid) begin
               if (op_ff == OP_INSERT) begin
                  mem_we        = 1'b1;
                  cnt_in        = cnt_ff + TSW'(1);
                  res_in.status = STATUS_INSERTED;
                  res_in.slot   = idx_ext[9:0];
               end
            end else if (match) begin
               res_in.slot = idx_ext[9:0];
               if (op_ff == OP_INSERT) begin
                  mem_we        = 1'b1;
                  res_in.status = STATUS_UPDATED;
               end else begin
                  res_in.record = rd_ff.record;
                  res_in.status = STATUS_FOUND;
               end
            end else begin
               idx_in = nidx;
            end
            res_in.entry_count = cnt_ext[10:0];
         end
         S_EMIT: begin
            if (emit) begin
               rsp_in       = res_ff;
               rsp_valid_in = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         ts_ff        <= TSW'(TABLE_DEPTH);
         cnt_ff       <= '0;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ts_ff        <= ts_in;
         cnt_ff       <= cnt_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff   <= op_in;
      key_ff  <= key_in;
      sh_ff   <= sh_in;
      len_ff  <= len_in;
      pay_ff  <= pay_in;
      ci_ff   <= ci_in;
      h1_ff   <= h1_in;
      h2_ff   <= h2_in;
      idx_ff  <= idx_in;
      home_ff <= home_in;
      step_ff <= step_in;
      res_ff  <= res_in;
      rsp_ff  <= rsp_in;
   end

   // slot table
   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_wa] <= mem_wd;
      rd_ff <= mem[idx_ff];
   end

   assign req_stall   = (state_ff != S_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

// ===== rtl/core/dhkt_check.sv =====
// port-level checks on the result channel of the key table, bound to the top level
// depends on dhkt_pkg and double_hash_key_table

module dhkt_check import dhkt_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_payload
);

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled result changed");

   a_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_payload.status <= STATUS_NOT_FOUND)
      else $error("bad status code");

   a_record: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.status != STATUS_FOUND |-> rsp_payload.record == '0)
      else $error("record set without a found lookup");

   a_slot: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_payload.status == STATUS_FULL ||
                    rsp_payload.status == STATUS_NOT_FOUND) |-> rsp_payload.slot == '0)
      else $error("slot set on a miss");

endmodule

bind double_hash_key_table dhkt_check u_dhkt_check (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_payload (rsp_payload)
);
